FILE: hw/rtl/nmea_pkg.sv
package nmea_pkg;

  localparam logic [7:0] COMMA_BYTE = 8'h2C;
  localparam logic [7:0] NUL_BYTE = 8'h00;
  localparam logic [7:0] CHAR_N = 8'h4E;
  localparam logic [7:0] CHAR_ZERO = 8'h30;

  localparam logic [3:0] RMC_MODE_FIELD = 4'd11;
  localparam logic [3:0] GGA_QUALITY_FIELD = 4'd5;
  localparam logic [3:0] FIELD_NUM_MAX = 4'd15;
  localparam logic [4:0] CHARS_MAX = 5'd31;
  localparam logic [2:0] HDR_POS_MAX = 3'd7;
  localparam logic [2:0] HDR_TEXT_FIRST = 3'd3;
  localparam logic [2:0] HDR_TEXT_LAST = 3'd5;
  localparam logic [2:0] HDR_MIN_LEN = 3'd6;

  // Field codes carried on the result channel.
  localparam logic [2:0] CODE_TIME = 3'd0;
  localparam logic [2:0] CODE_LAT = 3'd1;
  localparam logic [2:0] CODE_LAT_HEMI = 3'd2;
  localparam logic [2:0] CODE_LON = 3'd3;
  localparam logic [2:0] CODE_LON_HEMI = 3'd4;
  localparam logic [2:0] CODE_ALT = 3'd5;
  localparam logic [2:0] CODE_NONE = 3'd7;

  localparam logic KIND_RMC = 1'b0;
  localparam logic KIND_GGA = 1'b1;

  typedef struct packed {
    logic       in_header;
    logic [2:0] hdr_pos;
    logic       rmc_match;
    logic       gga_match;
    logic [3:0] field_num;
    logic [4:0] chars;
    logic       fix;
  } parse_state_t;

  typedef struct packed {
    logic       emit;
    logic       is_summary;
    logic [2:0] field_code;
    logic [3:0] char_index;
    logic [7:0] char_value;
    logic       kind;
    logic       fix;
  } parse_result_t;

  function automatic logic [2:0] field_code_of(input logic kind, input logic [3:0] field_num);
    logic [2:0] code;
    code = CODE_NONE;
    if (kind == KIND_RMC) begin
      case (field_num)
        4'd0: code = CODE_TIME;
        4'd2: code = CODE_LAT;
        4'd3: code = CODE_LAT_HEMI;
        4'd4: code = CODE_LON;
        4'd5: code = CODE_LON_HEMI;
        default: code = CODE_NONE;
      endcase
    end else begin
      case (field_num)
        4'd0: code = CODE_TIME;
        4'd1: code = CODE_LAT;
        4'd2: code = CODE_LAT_HEMI;
        4'd3: code = CODE_LON;
        4'd4: code = CODE_LON_HEMI;
        4'd8: code = CODE_ALT;
        default: code = CODE_NONE;
      endcase
    end
    return code;
  endfunction

  // Expected talker-stripped header text, indexed by header position minus three.
  function automatic logic [7:0] hdr_char(input logic kind, input logic [1:0] idx);
    logic [7:0] c;
    c = 8'h00;
    if (kind == KIND_RMC) begin
      case (idx)
        2'd0: c = 8'h52;
        2'd1: c = 8'h4D;
        2'd2: c = 8'h43;
        default: c = 8'h00;
      endcase
    end else begin
      case (idx)
        2'd0: c = 8'h47;
        2'd1: c = 8'h47;
        2'd2: c = 8'h41;
        default: c = 8'h00;
      endcase
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/nmea_step.sv
module nmea_step #(
  parameter int FIELD_CHARS = 16,
  parameter int ALTITUDE_CHARS = 8,
  parameter int SIGN_CHARS = 2
) (
  input  logic [7:0]             rx_byte,
  input  nmea_pkg::parse_state_t cur,
  output nmea_pkg::parse_state_t nxt,
  output nmea_pkg::parse_result_t res
);
  import nmea_pkg::*;

  localparam logic [4:0] FIELD_LIM = 5'(FIELD_CHARS);
  localparam logic [4:0] ALT_LIM = 5'(ALTITUDE_CHARS);
  localparam logic [4:0] SIGN_LIM = 5'(SIGN_CHARS);

  parse_state_t start_st;
  logic         kind;
  logic         fix_upd;
  logic [2:0]   code;
  logic [4:0]   limit;
  logic [1:0]   text_idx;

  always_comb begin
    start_st = '0;
    start_st.in_header = 1'b1;
    start_st.rmc_match = 1'b1;
    start_st.gga_match = 1'b1;
    start_st.fix = cur.fix;

    kind = cur.rmc_match ? KIND_RMC : KIND_GGA;
    text_idx = 2'(cur.hdr_pos - HDR_TEXT_FIRST);

    // The first byte of the mode or quality field sets the fix flag, even an empty field.
    fix_upd = cur.fix;
    if (cur.chars == 5'd0) begin
      if (kind == KIND_RMC && cur.field_num == RMC_MODE_FIELD) begin
        fix_upd = (rx_byte != CHAR_N);
      end
      if (kind == KIND_GGA && cur.field_num == GGA_QUALITY_FIELD) begin
        fix_upd = (rx_byte > CHAR_ZERO);
      end
    end

    code = field_code_of(kind, cur.field_num);
    case (code)
      CODE_LAT_HEMI, CODE_LON_HEMI: limit = SIGN_LIM;
      CODE_ALT: limit = ALT_LIM;
      default: limit = FIELD_LIM;
    endcase

    nxt = cur;
    res = '0;
    res.kind = kind;
    res.fix = fix_upd;

    if (cur.in_header) begin
      if (rx_byte == NUL_BYTE) begin
        nxt = start_st;
      end else if (rx_byte == COMMA_BYTE) begin
        if (cur.hdr_pos < HDR_MIN_LEN) begin
          nxt.rmc_match = 1'b0;
          nxt.gga_match = 1'b0;
        end
        nxt.in_header = 1'b0;
        nxt.field_num = '0;
        nxt.chars = '0;
      end else begin
        if (cur.hdr_pos >= HDR_TEXT_FIRST && cur.hdr_pos <= HDR_TEXT_LAST) begin
          if (rx_byte != hdr_char(KIND_RMC, text_idx)) nxt.rmc_match = 1'b0;
          if (rx_byte != hdr_char(KIND_GGA, text_idx)) nxt.gga_match = 1'b0;
        end
        if (cur.hdr_pos < HDR_POS_MAX) nxt.hdr_pos = cur.hdr_pos + 3'd1;
      end
    end else if (!cur.rmc_match && !cur.gga_match) begin
      if (rx_byte == NUL_BYTE) nxt = start_st;
    end else begin
      nxt.fix = fix_upd;
      if (rx_byte == NUL_BYTE) begin
        res.emit = 1'b1;
        res.is_summary = 1'b1;
        nxt = start_st;
        nxt.fix = fix_upd;
      end else if (rx_byte == COMMA_BYTE) begin
        if (cur.field_num < FIELD_NUM_MAX) nxt.field_num = cur.field_num + 4'd1;
        nxt.chars = '0;
      end else if (code != CODE_NONE && cur.chars < limit) begin
        res.emit = 1'b1;
        res.field_code = code;
        res.char_index = cur.chars[3:0];
        res.char_value = rx_byte;
        nxt.chars = cur.chars + 5'd1;
      end else if (cur.chars < CHARS_MAX) begin
        nxt.chars = cur.chars + 5'd1;
      end
    end
  end

endmodule

FILE: hw/rtl/nmea_rmc_gga_field_extractor_top.sv
// NMEA RMC/GGA field extractor.
//
// The input channel carries one sentence byte per item on in_rx_byte; a zero
// byte ends the sentence. The header runs up to the first comma, and its bytes
// three to five pick an RMC or a GGA sentence; other sentences are skipped.
// For matching sentences the result channel carries one item per captured
// character of the time, latitude, longitude, hemisphere and (GGA) altitude
// fields, tagged with a field code and the position in the field, and one
// summary item at the zero byte giving the sentence kind and the fix flag.
// Most input bytes cause no result item at all.
//
// Each accepted byte is parsed in the same cycle against the parser state and
// any result lands in the output register at the edge that accepted the byte,
// so it can be taken in the cycle after. One byte is taken every cycle while the
// output register is empty or being drained; in_stall rises only when a result
// is held and the receiver stalls, so throughput is one item per cycle.
//
// Reset returns the parser to the start of a sentence, clears the fix flag
// and empties the output register. The fix flag survives the end of a
// sentence. While out_stall is high a held result stays unchanged.
module nmea_rmc_gga_field_extractor_top #(
  parameter int FIELD_CHARS = 16,
  parameter int ALTITUDE_CHARS = 8,
  parameter int SIGN_CHARS = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_is_summary,
  output logic [2:0] out_field_code,
  output logic [3:0] out_char_index,
  output logic [7:0] out_char_value,
  output logic       out_sentence_kind,
  output logic       out_fix_valid
);
  import nmea_pkg::*;

  parse_state_t  state_r;
  parse_state_t  state_nxt;
  parse_state_t  reset_st;
  parse_result_t step_res;
  parse_result_t res_r;
  logic          out_valid_r;
  logic          in_accept;
  logic          out_free;

  // The output slot is free when empty or when its item leaves this cycle.
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !out_free;
  assign in_accept = in_valid && out_free;

  nmea_step #(
    .FIELD_CHARS(FIELD_CHARS),
    .ALTITUDE_CHARS(ALTITUDE_CHARS),
    .SIGN_CHARS(SIGN_CHARS)
  ) u_step (
    .rx_byte(in_rx_byte),
    .cur(state_r),
    .nxt(state_nxt),
    .res(step_res)
  );

  always_comb begin
    reset_st = '0;
    reset_st.in_header = 1'b1;
    reset_st.rmc_match = 1'b1;
    reset_st.gga_match = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= reset_st;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) state_r <= state_nxt;
      if (out_free) out_valid_r <= in_accept && step_res.emit;
    end
  end

  // Result payload needs no reset; it is qualified by out_valid_r.
  always_ff @(posedge clk) begin
    if (in_accept && step_res.emit) res_r <= step_res;
  end

  assign out_valid = out_valid_r;
  assign out_is_summary = res_r.is_summary;
  assign out_field_code = res_r.field_code;
  assign out_char_index = res_r.char_index;
  assign out_char_value = res_r.char_value;
  assign out_sentence_kind = res_r.kind;
  assign out_fix_valid = res_r.fix;

endmodule

FILE: tb/tb_nmea_rmc_gga_field_extractor_top.sv
`timescale 1ns / 1ps

module tb_nmea_rmc_gga_field_extractor_top;
  import nmea_pkg::*;

  // Field limits given to the block. The predictor uses the same values.
  localparam int FIELD_CHARS = 16;
  localparam int ALTITUDE_CHARS = 8;
  localparam int SIGN_CHARS = 2;

  // The run is aborted when neither channel moves an item for this many cycles.
  localparam int WATCHDOG_LIMIT = 2000;
  // Bytes of RMC and GGA sentences to send in the random phase.
  localparam int RANDOM_BYTES = 750;

  // Header text that selects each sentence kind, at header positions three to five.
  localparam logic [23:0] RMC_TAG = "RMC";
  localparam logic [23:0] GGA_TAG = "GGA";

  // One expected item of the result channel.
  typedef struct packed {
    logic       summary;
    logic [2:0] code;
    logic [3:0] pos;
    logic [7:0] value;
    logic       kind;
    logic       fix;
  } field_item_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_is_summary;
  logic [2:0] out_field_code;
  logic [3:0] out_char_index;
  logic [7:0] out_char_value;
  logic       out_sentence_kind;
  logic       out_fix_valid;

  nmea_rmc_gga_field_extractor_top #(
    .FIELD_CHARS(FIELD_CHARS),
    .ALTITUDE_CHARS(ALTITUDE_CHARS),
    .SIGN_CHARS(SIGN_CHARS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_rx_byte(in_rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_is_summary(out_is_summary),
    .out_field_code(out_field_code),
    .out_char_index(out_char_index),
    .out_char_value(out_char_value),
    .out_sentence_kind(out_sentence_kind),
    .out_fix_valid(out_fix_valid)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Parser state as the predictor tracks it. The fix flag outlives a sentence.
  logic       st_in_header = 1'b1;
  logic [2:0] st_hdr_len = 3'd0;
  logic       st_rmc = 1'b1;
  logic       st_gga = 1'b1;
  logic [3:0] st_field = 4'd0;
  logic [4:0] st_chars = 5'd0;
  logic       st_fix = 1'b0;

  // Result items predicted but not yet seen on the output, oldest first.
  field_item_t pending_fields[$];
  int error_count = 0;
  int quiet_cycles = 0;

  // Controls shared by the test tasks, the sender and the receiver. A quiet
  // side never idles; a nonzero hold request makes the receiver stall for
  // that many cycles in a row.
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  int hold_request = 0;

  // Sentence under construction; sent byte by byte by send_line.
  logic [7:0] line_buf[$];

  function automatic void clear_sentence();
    st_in_header = 1'b1;
    st_hdr_len = 3'd0;
    st_rmc = 1'b1;
    st_gga = 1'b1;
    st_field = 4'd0;
    st_chars = 5'd0;
  endfunction

  // Which output field code a sentence field feeds, or none.
  function automatic logic [2:0] capture_code(input logic kind, input logic [3:0] field);
    if (field == 4'd0) return CODE_TIME;
    if (kind == KIND_RMC && field >= 4'd2 && field <= 4'd5) return field[2:0] - 3'd1;
    if (kind == KIND_GGA && field >= 4'd1 && field <= 4'd4) return field[2:0];
    if (kind == KIND_GGA && field == 4'd8) return CODE_ALT;
    return CODE_NONE;
  endfunction

  // Advances the predicted parser by one accepted byte and queues the result
  // item that the byte causes, if any.
  function automatic void parse_nmea_byte(input logic [7:0] b);
    logic        kind;
    logic [2:0]  code;
    int          limit;
    field_item_t item;
    if (st_in_header) begin
      if (b == NUL_BYTE) begin
        clear_sentence();
      end else if (b == COMMA_BYTE) begin
        if (st_hdr_len < HDR_MIN_LEN) begin
          st_rmc = 1'b0;
          st_gga = 1'b0;
        end
        st_in_header = 1'b0;
        st_field = 4'd0;
        st_chars = 5'd0;
      end else begin
        if (st_hdr_len >= 3'd3 && st_hdr_len <= 3'd5) begin
          if (b != RMC_TAG[8 * (5 - st_hdr_len) +: 8]) st_rmc = 1'b0;
          if (b != GGA_TAG[8 * (5 - st_hdr_len) +: 8]) st_gga = 1'b0;
        end
        if (st_hdr_len != 3'd7) st_hdr_len = st_hdr_len + 3'd1;
      end
      return;
    end
    if (!st_rmc && !st_gga) begin
      if (b == NUL_BYTE) clear_sentence();
      return;
    end
    kind = st_rmc ? KIND_RMC : KIND_GGA;
    // The first byte of the mode or quality field decides the fix, even a
    // comma or the terminating zero.
    if (st_chars == 5'd0) begin
      if (kind == KIND_RMC && st_field == RMC_MODE_FIELD) st_fix = (b != CHAR_N);
      if (kind == KIND_GGA && st_field == GGA_QUALITY_FIELD) st_fix = (b > CHAR_ZERO);
    end
    item = '0;
    item.kind = kind;
    item.fix = st_fix;
    if (b == NUL_BYTE) begin
      item.summary = 1'b1;
      pending_fields.push_back(item);
      clear_sentence();
      return;
    end
    if (b == COMMA_BYTE) begin
      if (st_field != 4'd15) st_field = st_field + 4'd1;
      st_chars = 5'd0;
      return;
    end
    code = capture_code(kind, st_field);
    case (code)
      CODE_LAT_HEMI, CODE_LON_HEMI: limit = SIGN_CHARS;
      CODE_ALT: limit = ALTITUDE_CHARS;
      default: limit = FIELD_CHARS;
    endcase
    if (code != CODE_NONE && st_chars < limit) begin
      item.code = code;
      item.pos = st_chars[3:0];
      item.value = b;
      pending_fields.push_back(item);
    end
    if (st_chars != 5'd31) st_chars = st_chars + 5'd1;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  // Everything is sampled on the falling edge, where the values that the next
  // rising edge will see are settled. A handshake seen here completes at that
  // next edge. Output items are checked before the input byte is predicted, so
  // an unexpected item can never pair up with a prediction made in the same
  // cycle. The watchdog counts cycles in which neither channel moves an item.
  always @(negedge clk) begin : monitor
    field_item_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_fields.size() == 0) begin
          $error("unexpected result item: summary %0b code %0d index %0d value %0h",
                 out_is_summary, out_field_code, out_char_index, out_char_value);
          error_count++;
        end else begin
          want = pending_fields.pop_front();
          check_field("out_is_summary", 8'(want.summary), 8'(out_is_summary));
          check_field("out_field_code", 8'(want.code), 8'(out_field_code));
          check_field("out_char_index", 8'(want.pos), 8'(out_char_index));
          check_field("out_char_value", want.value, out_char_value);
          check_field("out_sentence_kind", 8'(want.kind), 8'(out_sentence_kind));
          check_field("out_fix_valid", 8'(want.fix), 8'(out_fix_valid));
        end
      end
      if (in_valid && !in_stall) parse_nmea_byte(in_rx_byte);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Idle stretch length: mostly short, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // The receiver alternates runs of ready cycles with stall stretches. A hold
  // request from a test overrides this with one long stall of counted length.
  initial begin : receiver
    int n;
    repeat (8) @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end else if (rx_quiet || $urandom_range(0, 99) < 65) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat (idle_len()) @(posedge clk);
      end
    end
  end

  // Offers one byte, with a random gap before it unless the sender is quiet,
  // and returns right after the rising edge that accepts it. Valid only ever
  // gets one assignment in a time step: it is lowered for a gap or raised for
  // the byte, never both.
  task automatic send_rx_byte(input logic [7:0] b);
    int gap;
    gap = (!tx_quiet && $urandom_range(0, 99) < 35) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic line_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic line_fill(input logic [7:0] b, input int n);
    repeat (n) line_buf.push_back(b);
  endtask

  // Sends the buffered bytes, followed by the terminating zero when asked.
  task automatic send_line(input bit terminate);
    int i;
    for (i = 0; i < line_buf.size(); i++) send_rx_byte(line_buf[i]);
    if (terminate) send_rx_byte(NUL_BYTE);
    line_buf.delete();
  endtask

  task automatic send_sentence(input string s);
    line_text(s);
    send_line(1'b1);
  endtask

  // Stops offering bytes until every predicted item has come out.
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_fields.size() != 0);
  endtask

  // Typical sentences of both kinds with every captured field filled in.
  task automatic test_rmc_fields();
    send_sentence("$GPRMC,123519.00,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W,A*6A");
  endtask

  task automatic test_gga_fields();
    send_sentence("$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47");
  endtask

  // A header too short to match, a zero byte inside the header, a sentence of
  // another type, and a header long enough to saturate its position counter.
  task automatic test_header_cases();
    send_sentence("$RMC,12,34");
    send_sentence("$GPR");
    send_sentence("$GPGSV,1,2,N");
    send_sentence("$GPRMCABCDEF,1,,2");
  endtask

  // Fields longer than their limits, a skipped field long enough to saturate
  // the character count, and enough commas to saturate the field count.
  task automatic test_field_limits();
    line_text("$GPRMC,12345678901234567890,A,48070380123456789,NNN,");
    line_text("0113100012345678X,EEEE,");
    line_fill("7", 34);
    line_fill(COMMA_BYTE, 12);
    line_text("Q");
    send_line(1'b1);
    send_sentence("$GNGGA,,,,,,2,,,12345678901,M");
  endtask

  // Fix decisions from the first byte of the RMC mode field and of the GGA
  // quality field, including empty fields, a zero byte at the field start, a
  // byte above the ASCII range and a quality field longer than one byte.
  task automatic test_fix_field_edges();
    line_text("$GPRMC");
    line_fill(COMMA_BYTE, 12);
    line_text("NX");
    send_line(1'b1);
    line_text("$GPRMC");
    line_fill(COMMA_BYTE, 12);
    send_line(1'b1);
    line_text("$GPRMC");
    line_fill(COMMA_BYTE, 12);
    line_text("N");
    send_line(1'b1);
    line_text("$GPRMC");
    line_fill(COMMA_BYTE, 13);
    line_text("N");
    send_line(1'b1);
    send_sentence("$GPGGA,,,,,,0");
    send_sentence("$GPGGA,,,,,,1");
    line_text("$GPGGA,,,,,,");
    line_fill(8'h80, 1);
    send_line(1'b1);
    send_sentence("$GPGGA,,,,,,,1");
    send_sentence("$GPGGA,,,,,,");
    line_text("$GPGGA,,,,,,12,3,4,5.5,M");
    line_fill(8'hFF, 1);
    send_line(1'b1);
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // a sentence full of captured characters, so the output register stays full
  // and the block has to stall its input.
  task automatic test_backpressure();
    hold_request = 150;
    while (hold_request != 0) @(posedge clk);
    tx_quiet = 1'b1;
    send_sentence("$GNGGA,235959.999,3344.5566,S,11122.3344,W,4,12,0.5,12345.67,M");
    tx_quiet = 1'b0;
  endtask

  // The sender stops in the middle of a sentence until all results are out,
  // then finishes it; the parser must keep its place across the pause.
  task automatic test_drain_pause();
    line_text("$GPGGA,1234");
    send_line(1'b0);
    wait_drain();
    line_text("56,5012.1,N,00002.5,E,1");
    send_line(1'b0);
    wait_drain();
    line_text(",08,1.1,88.5,M");
    send_line(1'b1);
    wait_drain();
  endtask

  function automatic logic [7:0] rand_char();
    logic [7:0] c;
    if ($urandom_range(0, 99) < 80) c = 8'h2E + 8'($urandom_range(0, 76));
    else c = 8'($urandom_range(1, 255));
    if (c == COMMA_BYTE) c = 8'h2D;
    return c;
  endfunction

  function automatic logic [7:0] rand_letter();
    return 8'h41 + 8'($urandom_range(0, 25));
  endfunction

  function automatic int rand_field_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 4);
    if (r < 90) return $urandom_range(5, 12);
    if (r < 98) return $urandom_range(13, 20);
    return $urandom_range(30, 34);
  endfunction

  // Builds one random sentence into the line buffer. Most are well-formed RMC
  // or GGA sentences with random content; the rest are other sentence types,
  // odd header lengths and raw noise. Only RMC and GGA sentences are counted.
  task automatic build_random_sentence(output bit counted);
    int r, nf, fix_field, i, j;
    counted = 1'b0;
    r = $urandom_range(0, 99);
    if (r >= 94) begin
      repeat ($urandom_range(3, 40)) line_buf.push_back(8'($urandom_range(0, 255)));
      return;
    end
    line_text("$");
    repeat (2) line_buf.push_back(($urandom_range(0, 9) == 0) ? rand_char() : rand_letter());
    if (r < 40) begin
      line_text("RMC");
      counted = 1'b1;
    end else if (r < 80) begin
      line_text("GGA");
      counted = 1'b1;
    end else if (r < 88) begin
      repeat (3) line_buf.push_back(rand_letter());
    end else begin
      repeat ($urandom_range(0, 7)) line_buf.push_back(rand_char());
    end
    if (counted && $urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3)) line_buf.push_back(rand_char());
    end
    fix_field = (r < 40) ? RMC_MODE_FIELD : GGA_QUALITY_FIELD;
    if ($urandom_range(0, 99) < 85) nf = (r < 40) ? 13 : 15;
    else nf = $urandom_range(0, 17);
    for (i = 0; i < nf; i++) begin
      line_buf.push_back(COMMA_BYTE);
      if (i == fix_field) begin
        case ($urandom_range(0, 7))
          0: line_text("N");
          1: line_text("A");
          2: line_text("D");
          3: line_text("0");
          4: line_text("1");
          5: line_text("6");
          6: ;
          default: line_buf.push_back(rand_char());
        endcase
        repeat ($urandom_range(0, 2)) line_buf.push_back(rand_char());
      end else begin
        j = rand_field_len();
        repeat (j) line_buf.push_back(rand_char());
      end
    end
  endtask

  task automatic test_random_sentences();
    int sent_bytes;
    bit counted;
    sent_bytes = 0;
    while (sent_bytes < RANDOM_BYTES) begin
      tx_quiet = ($urandom_range(0, 99) < 20);
      rx_quiet = ($urandom_range(0, 99) < 20);
      build_random_sentence(counted);
      if (counted) sent_bytes += line_buf.size() + 1;
      send_line(1'b1);
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // Reset once, then the directed tests, the pressure tests and the random
  // phase. At the end the sender waits for every predicted item and then keeps
  // the run going, so that a stray item after the last one is still caught.
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_rmc_fields();
    test_gga_fields();
    test_header_cases();
    test_field_limits();
    test_fix_field_edges();
    test_backpressure();
    test_drain_pause();
    test_random_sentences();
    wait_drain();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
